/* design/pspf_pkg.sv */
// Shared types, constants and codes of the Pockels setpoint feedback block.
package pspf_pkg;

	// Field widths
	localparam int ASYM_W  = 32;
	localparam int ERR_W   = 31;
	localparam int SP_W    = 32;
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 3;
	localparam int FRAC_W  = 16;

	// Divider: dividend is |asymmetry| scaled by 2^16
	localparam int DVD_W     = ASYM_W + FRAC_W;
	localparam int DVS_W     = 32;
	localparam int DIV_STEPS = DVD_W;
	localparam int DCNT_W    = $clog2(DIV_STEPS);

	// Sum width: setpoint plus a signed correction of up to 48 bits
	localparam int SUM_W = DVD_W + 2;

	// Damping thresholds on |asymmetry| (Q16.16 ppm)
	localparam logic [ASYM_W-1:0] TH_HUNDREDTH = 32'd656;
	localparam logic [ASYM_W-1:0] TH_TENTH     = 32'd6554;
	localparam logic [ASYM_W-1:0] TH_ONE       = 32'd65536;
	localparam logic [ASYM_W-1:0] TH_TWO       = 32'd131072;
	localparam logic [ASYM_W-1:0] TH_FIVE      = 32'd327680;

	// Reciprocal multiply: exact x/10 and x/100 for any 32-bit x
	localparam int               RECIP_W   = 32;
	localparam logic [RECIP_W-1:0] RECIP_10  = 32'hCCCC_CCCD;
	localparam int               SHR_10    = 35;
	localparam logic [RECIP_W-1:0] RECIP_100 = 32'h51EB_851F;
	localparam int               SHR_100   = 37;

	// Mode bits
	localparam int MODE_DAMP = 0;
	localparam int MODE_T0   = 1;

	// Configuration register indexes
	typedef enum logic [IDX_W-1:0] {
		CFG_SLOPE     = 3'd0,
		CFG_MIN_ASYM  = 3'd1,
		CFG_ERR_PREC  = 3'd2,
		CFG_SP_LOW    = 3'd3,
		CFG_SP_HIGH   = 3'd4,
		CFG_MODE      = 3'd5,
		CFG_T0_PLUS   = 3'd6,
		CFG_T0_MINUS  = 3'd7
	} cfg_idx_t;

	// Result codes
	typedef enum logic [2:0] {
		ACT_STATS_INVALID = 3'd0,
		ACT_IMPRECISE     = 3'd1,
		ACT_TOO_SMALL     = 3'd2,
		ACT_T0_APPLIED    = 3'd3,
		ACT_APPLIED       = 3'd4,
		ACT_OUT_OF_BOUNDS = 3'd5
	} action_t;

	// Damping range selected by |asymmetry|
	typedef enum logic [2:0] {
		DAMP_NONE,
		DAMP_100,
		DAMP_10,
		DAMP_4,
		DAMP_2,
		DAMP_34
	} damp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GATE,
		ST_DIV,
		ST_DAMP,
		ST_ADD,
		ST_CHECK,
		ST_EMIT
	} state_t;

	// Configuration registers
	typedef struct packed {
		logic signed [ASYM_W-1:0] slope;
		logic [ERR_W-1:0]         min_asym;
		logic [ERR_W-1:0]         err_prec;
		logic [SP_W-1:0]          sp_low;
		logic [SP_W-1:0]          sp_high;
		logic [MODE_W-1:0]        mode;
		logic [SP_W-1:0]          t0_plus;
		logic [SP_W-1:0]          t0_minus;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic    load_in;
		logic    div_start;
		damp_t   damp;
		logic    corr_clear;
		logic    corr_from_div;
		logic    corr_scale;
		logic    sum_en;
		logic    out_load;
		action_t action;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic  invalid;
		logic  imprecise;
		logic  too_small;
		logic  slope_zero;
		logic  oob;
		logic  div_done;
		logic  out_free;
		damp_t damp;
	} status_t;

endpackage

/* design/pockels_setpoint_feedback.sv */
// Top level of the Pockels setpoint feedback block: ports, config registers, wiring.
//
// One feedback request is handled at a time; s_tready is high only while the controller
// is idle. A request rejected by the statistics, precision or minimum-asymmetry gates,
// or one that applies the stored t0 setpoints, goes from the gate state to the emit
// state; a zero slope skips the divider and passes through the add and check states.
// A correction runs the asymmetry over the slope through a bit-serial divider, then the
// damp, add and check states; damping is by 1/100 or 1/10 through a reciprocal multiply,
// or by shifts and an add. The next request is taken the cycle after a result is loaded,
// and none while one is still in progress. The result waits in an output register,
// so a new request is taken while it is pending; a later result waits until it is free.
module pockels_setpoint_feedback (
	input  logic         clk,
	input  logic         arst_n,
	// Configuration write port
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// Requests
	input  logic         s_tvalid,
	output logic         s_tready,
	// asymmetry[31:0], asymmetry_error[62:32], prior_plus[94:63], prior_minus[126:95]
	input  logic [127:0] s_tdata,
	// stats_valid[0]
	input  logic         s_tuser,
	// Results
	output logic         m_tvalid,
	input  logic         m_tready,
	// next_plus[31:0], next_minus[63:32]
	output logic [63:0]  m_tdata,
	// action[2:0], write_setpoints[3], clear_sums[4]
	output logic [4:0]   m_tuser
);

	pspf_pkg::cfg_t     cfg_q;
	pspf_pkg::cmd_t     cmd;
	pspf_pkg::status_t  sts;
	pspf_pkg::action_t  out_action;
	logic               out_write;
	logic               out_clear;
	logic [31:0]        out_plus;
	logic [31:0]        out_minus;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slope    <= '0;
			cfg_q.min_asym <= '0;
			cfg_q.err_prec <= '0;
			cfg_q.sp_low   <= '0;
			cfg_q.sp_high  <= '1;
			cfg_q.mode     <= '0;
			cfg_q.t0_plus  <= '0;
			cfg_q.t0_minus <= '0;
		end else if (cfg_we) begin
			case (pspf_pkg::cfg_idx_t'(cfg_index))
				pspf_pkg::CFG_SLOPE:    cfg_q.slope    <= cfg_data;
				pspf_pkg::CFG_MIN_ASYM: cfg_q.min_asym <= cfg_data[pspf_pkg::ERR_W-1:0];
				pspf_pkg::CFG_ERR_PREC: cfg_q.err_prec <= cfg_data[pspf_pkg::ERR_W-1:0];
				pspf_pkg::CFG_SP_LOW:   cfg_q.sp_low   <= cfg_data;
				pspf_pkg::CFG_SP_HIGH:  cfg_q.sp_high  <= cfg_data;
				pspf_pkg::CFG_MODE:     cfg_q.mode     <= cfg_data[pspf_pkg::MODE_W-1:0];
				pspf_pkg::CFG_T0_PLUS:  cfg_q.t0_plus  <= cfg_data;
				pspf_pkg::CFG_T0_MINUS: cfg_q.t0_minus <= cfg_data;
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	pspf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.mode     (cfg_q.mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	pspf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_asym    (s_tdata[31:0]),
		.in_err     (s_tdata[62:32]),
		.in_valid   (s_tuser),
		.in_plus    (s_tdata[94:63]),
		.in_minus   (s_tdata[126:95]),
		.cmd        (cmd),
		.sts        (sts),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_action (out_action),
		.out_write  (out_write),
		.out_plus   (out_plus),
		.out_minus  (out_minus),
		.out_clear  (out_clear)
	);

	// Result packing
	assign m_tdata = {out_minus, out_plus};
	assign m_tuser = {out_clear, out_write, out_action};

endmodule

/* design/pspf_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
module pspf_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [pspf_pkg::DVD_W-1:0]     dividend,
	input  logic [pspf_pkg::DVS_W-1:0]     divisor,
	output logic                           done,
	output logic [pspf_pkg::DVD_W-1:0]     quotient
);

	logic                            busy_q;
	logic                            done_q;
	logic [pspf_pkg::DCNT_W-1:0]     cnt_q;
	logic [pspf_pkg::DVD_W-1:0]      quo_q;
	logic [pspf_pkg::DVS_W-1:0]      rem_q;
	logic [pspf_pkg::DVS_W-1:0]      den_q;
	logic [pspf_pkg::DVS_W:0]        rem_sh;
	logic [pspf_pkg::DVS_W:0]        rem_sub;
	logic                            ge;
	logic                            last_step;

	// Shift in the next dividend bit and try the subtraction
	always_comb begin
		rem_sh    = {rem_q, quo_q[pspf_pkg::DVD_W-1]};
		ge        = rem_sh >= {1'b0, den_q};
		rem_sub   = rem_sh - {1'b0, den_q};
		last_step = cnt_q == pspf_pkg::DCNT_W'(pspf_pkg::DIV_STEPS - 1);
	end

	// Control: busy flag, step counter, done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && last_step;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_step)
					busy_q <= 1'b0;
			end
		end
	end

	// Quotient and remainder shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			den_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[pspf_pkg::DVD_W-2:0], ge};
			rem_q <= ge ? rem_sub[pspf_pkg::DVS_W-1:0] : rem_sh[pspf_pkg::DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

/* design/pspf_ctrl.sv */
// Controller: sequences gating, division, damping, bound check and result hand-off.
module pspf_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pspf_pkg::MODE_W-1:0]   mode,
	input  pspf_pkg::status_t             sts,
	output pspf_pkg::cmd_t                cmd
);

	pspf_pkg::state_t  state_q, state_d;
	pspf_pkg::action_t act_q, act_d;
	logic              t0_pending_q, t0_pending_d;
	pspf_pkg::damp_t   damp_eff;

	// State, result code and t0 flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= pspf_pkg::ST_IDLE;
			act_q        <= pspf_pkg::ACT_STATS_INVALID;
			t0_pending_q <= 1'b1;
		end else begin
			state_q      <= state_d;
			act_q        <= act_d;
			t0_pending_q <= t0_pending_d;
		end
	end

	// Damping only when enabled
	assign damp_eff = mode[pspf_pkg::MODE_DAMP] ? sts.damp : pspf_pkg::DAMP_NONE;

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		act_d         = act_q;
		t0_pending_d  = t0_pending_q;
		s_tready      = 1'b0;
		cmd           = '0;
		cmd.damp      = damp_eff;
		cmd.action    = act_q;
		case (state_q)
			pspf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = pspf_pkg::ST_GATE;
				end
			end
			pspf_pkg::ST_GATE: begin
				if (sts.invalid) begin
					act_d   = pspf_pkg::ACT_STATS_INVALID;
					state_d = pspf_pkg::ST_EMIT;
				end else if (sts.imprecise) begin
					act_d   = pspf_pkg::ACT_IMPRECISE;
					state_d = pspf_pkg::ST_EMIT;
				end else if (sts.too_small) begin
					act_d   = pspf_pkg::ACT_TOO_SMALL;
					state_d = pspf_pkg::ST_EMIT;
				end else if (mode[pspf_pkg::MODE_T0] && t0_pending_q) begin
					act_d        = pspf_pkg::ACT_T0_APPLIED;
					t0_pending_d = 1'b0;
					state_d      = pspf_pkg::ST_EMIT;
				end else if (sts.slope_zero) begin
					cmd.corr_clear = 1'b1;
					state_d        = pspf_pkg::ST_ADD;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = pspf_pkg::ST_DIV;
				end
			end
			pspf_pkg::ST_DIV: begin
				if (sts.div_done) begin
					cmd.corr_from_div = 1'b1;
					state_d           = pspf_pkg::ST_DAMP;
				end
			end
			pspf_pkg::ST_DAMP: begin
				case (damp_eff)
					pspf_pkg::DAMP_NONE: begin
						state_d = pspf_pkg::ST_ADD;
					end
					default: begin
						cmd.corr_scale = 1'b1;
						state_d        = pspf_pkg::ST_ADD;
					end
				endcase
			end
			pspf_pkg::ST_ADD: begin
				cmd.sum_en = 1'b1;
				state_d    = pspf_pkg::ST_CHECK;
			end
			pspf_pkg::ST_CHECK: begin
				act_d   = sts.oob ? pspf_pkg::ACT_OUT_OF_BOUNDS : pspf_pkg::ACT_APPLIED;
				state_d = pspf_pkg::ST_EMIT;
			end
			pspf_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = pspf_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pspf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* design/pspf_dp.sv */
// Datapath: request registers, gating compares, correction, sums and result register.
module pspf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  pspf_pkg::cfg_t                cfg,
	input  logic [pspf_pkg::ASYM_W-1:0]   in_asym,
	input  logic [pspf_pkg::ERR_W-1:0]    in_err,
	input  logic                          in_valid,
	input  logic [pspf_pkg::SP_W-1:0]     in_plus,
	input  logic [pspf_pkg::SP_W-1:0]     in_minus,
	input  pspf_pkg::cmd_t                cmd,
	output pspf_pkg::status_t             sts,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pspf_pkg::action_t             out_action,
	output logic                          out_write,
	output logic [pspf_pkg::SP_W-1:0]     out_plus,
	output logic [pspf_pkg::SP_W-1:0]     out_minus,
	output logic                          out_clear
);

	logic [pspf_pkg::ASYM_W-1:0]     asym_q;
	logic [pspf_pkg::ERR_W-1:0]      err_q;
	logic                            valid_q;
	logic [pspf_pkg::SP_W-1:0]       plus_q;
	logic [pspf_pkg::SP_W-1:0]       minus_q;
	logic [pspf_pkg::DVD_W-1:0]      corr_q;
	logic signed [pspf_pkg::SUM_W-1:0] np_q;
	logic signed [pspf_pkg::SUM_W-1:0] nm_q;
	logic                            out_valid_q;

	logic [pspf_pkg::ASYM_W-1:0]     mag;
	logic [pspf_pkg::ASYM_W-1:0]     slope_mag;
	logic                            neg;
	pspf_pkg::damp_t                 damp;
	logic [pspf_pkg::DVD_W-1:0]      div_dvd;
	logic [pspf_pkg::DVS_W-1:0]      div_dvs;
	logic                            div_done;
	logic [pspf_pkg::DVD_W-1:0]      div_quo;
	logic [pspf_pkg::DVD_W+1:0]      three_c;
	logic [pspf_pkg::RECIP_W-1:0]    recip;
	logic [2*pspf_pkg::RECIP_W-1:0]  prod;
	logic [pspf_pkg::DVD_W-1:0]      scaled;
	logic signed [pspf_pkg::SUM_W-1:0] cmag;
	logic signed [pspf_pkg::SUM_W-1:0] scorr;
	logic signed [pspf_pkg::SUM_W-1:0] hi_s;
	logic signed [pspf_pkg::SUM_W-1:0] lo_s;

	// Request registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			asym_q  <= in_asym;
			err_q   <= in_err;
			valid_q <= in_valid;
			plus_q  <= in_plus;
			minus_q <= in_minus;
		end
	end

	// Magnitudes and sign of the correction
	always_comb begin
		mag       = asym_q[pspf_pkg::ASYM_W-1] ? (~asym_q + 1'b1) : asym_q;
		slope_mag = cfg.slope[pspf_pkg::ASYM_W-1] ? (~cfg.slope + 1'b1) : cfg.slope;
		neg       = asym_q[pspf_pkg::ASYM_W-1] ^ cfg.slope[pspf_pkg::ASYM_W-1];
	end

	// Damping range
	always_comb begin
		if (mag < pspf_pkg::TH_HUNDREDTH)   damp = pspf_pkg::DAMP_100;
		else if (mag < pspf_pkg::TH_TENTH)  damp = pspf_pkg::DAMP_10;
		else if (mag < pspf_pkg::TH_ONE)    damp = pspf_pkg::DAMP_4;
		else if (mag < pspf_pkg::TH_TWO)    damp = pspf_pkg::DAMP_2;
		else if (mag < pspf_pkg::TH_FIVE)   damp = pspf_pkg::DAMP_34;
		else                                damp = pspf_pkg::DAMP_NONE;
	end

	// Divider: asymmetry over slope
	always_comb begin
		div_dvd = {mag, {pspf_pkg::FRAC_W{1'b0}}};
		div_dvs = slope_mag;
	end

	pspf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	// Damping on the correction magnitude; below 0.1 ppm the magnitude is under
	// 2^32 (|slope| >= 1), so a reciprocal multiply gives the exact quotient
	always_comb begin
		three_c = {2'b00, corr_q} + {1'b0, corr_q, 1'b0};
		recip   = (cmd.damp == pspf_pkg::DAMP_100) ? pspf_pkg::RECIP_100 : pspf_pkg::RECIP_10;
		prod    = {{pspf_pkg::RECIP_W{1'b0}}, corr_q[pspf_pkg::RECIP_W-1:0]} *
			{{pspf_pkg::RECIP_W{1'b0}}, recip};
		case (cmd.damp)
			pspf_pkg::DAMP_100: scaled = pspf_pkg::DVD_W'(prod >> pspf_pkg::SHR_100);
			pspf_pkg::DAMP_10:  scaled = pspf_pkg::DVD_W'(prod >> pspf_pkg::SHR_10);
			pspf_pkg::DAMP_4:   scaled = corr_q >> 2;
			pspf_pkg::DAMP_2:   scaled = corr_q >> 1;
			pspf_pkg::DAMP_34:  scaled = three_c[pspf_pkg::DVD_W+1:2];
			default:            scaled = corr_q;
		endcase
	end

	// Correction magnitude register
	always_ff @(posedge clk) begin
		if (cmd.corr_clear)
			corr_q <= '0;
		else if (cmd.corr_from_div)
			corr_q <= div_quo;
		else if (cmd.corr_scale)
			corr_q <= scaled;
	end

	// New setpoints, wide enough not to wrap
	always_comb begin
		cmag  = $signed({2'b00, corr_q});
		scorr = neg ? -cmag : cmag;
		hi_s  = $signed({{(pspf_pkg::SUM_W-pspf_pkg::SP_W){1'b0}}, cfg.sp_high});
		lo_s  = $signed({{(pspf_pkg::SUM_W-pspf_pkg::SP_W){1'b0}}, cfg.sp_low});
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			np_q <= $signed({{(pspf_pkg::SUM_W-pspf_pkg::SP_W){1'b0}}, plus_q}) + scorr;
			nm_q <= $signed({{(pspf_pkg::SUM_W-pspf_pkg::SP_W){1'b0}}, minus_q}) - scorr;
		end
	end

	// Status to the controller
	always_comb begin
		sts.invalid    = !valid_q;
		sts.imprecise  = err_q > cfg.err_prec;
		sts.too_small  = mag < {1'b0, cfg.min_asym};
		sts.slope_zero = cfg.slope == '0;
		sts.oob        = (np_q > hi_s) || (np_q < lo_s) || (nm_q > hi_s) || (nm_q < lo_s);
		sts.div_done   = div_done;
		sts.out_free   = !out_valid_q || out_ready;
		sts.damp       = damp;
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_action <= cmd.action;
			case (cmd.action)
				pspf_pkg::ACT_T0_APPLIED: begin
					out_write <= 1'b1;
					out_clear <= 1'b0;
					out_plus  <= cfg.t0_plus;
					out_minus <= cfg.t0_minus;
				end
				pspf_pkg::ACT_APPLIED: begin
					out_write <= 1'b1;
					out_clear <= 1'b1;
					out_plus  <= np_q[pspf_pkg::SP_W-1:0];
					out_minus <= nm_q[pspf_pkg::SP_W-1:0];
				end
				default: begin
					out_write <= 1'b0;
					out_clear <= 1'b0;
					out_plus  <= plus_q;
					out_minus <= minus_q;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule
